FILE: rtl/core/rcs_pkg.sv
// Shared types, constants and symbol encoding for the random code sampler.
`default_nettype none

package rcs_pkg;

   localparam int WORD_W         = 31;
   localparam int DIV_RADIX_BITS = 4;
   localparam int DIV_STEPS      = 8;
   localparam int DIV_CNT_W      = 3;
   localparam int DIV_WORD_W     = DIV_STEPS * DIV_RADIX_BITS;
   localparam int SYM_W          = 6;
   localparam int LEN_W          = 5;
   localparam int CFG_W          = 5;

   localparam logic [1:0] MODE_DIGITS          = 2'd0;
   localparam logic [1:0] MODE_DISTINCT_DIGITS = 2'd1;
   localparam logic [1:0] MODE_DISTINCT_ALNUM  = 2'd2;

   localparam logic CSR_CODE_MODE   = 1'b0;
   localparam logic CSR_CODE_LENGTH = 1'b1;

   localparam logic [LEN_W-1:0] CODE_LENGTH_RESET = 5'd4;

   localparam logic [6:0] ASCII_ZERO    = 7'd48;
   localparam logic [6:0] ASCII_LOWER_A = 7'd97;
   localparam logic [6:0] ASCII_UPPER_A = 7'd65;

   localparam logic [SYM_W-1:0] DIGIT_COUNT = 6'd10;
   localparam logic [SYM_W-1:0] LETTER_BASE = 6'd36;

   typedef struct packed {
      logic start;
      logic div_step;
      logic tbl_read;
      logic wr_pick;
      logic wr_tail;
      logic finish;
   } rcs_cmd_type;

   typedef struct packed {
      logic distinct;
      logic out_full;
   } rcs_sts_type;

   function automatic logic [6:0] sym_ascii(input logic [SYM_W-1:0] k);
      logic [6:0] k7;
      k7 = {1'b0, k};
      if (k < DIGIT_COUNT)
         return ASCII_ZERO + k7;
      else if (k < LETTER_BASE)
         return ASCII_LOWER_A + k7 - {1'b0, DIGIT_COUNT};
      else
         return ASCII_UPPER_A + k7 - {1'b0, LETTER_BASE};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rcs_ctrl.sv
// Sequencer for one beat: divide, table read and swap in distinct modes, result load.
`default_nettype none

module rcs_ctrl
   import rcs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire rcs_sts_type sts,
   output rcs_cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_SWAP_PICK,
      ST_SWAP_TAIL,
      ST_EMIT
   } state_type;

   state_type              state_ff;
   state_type              state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff;
   logic [DIV_CNT_W-1:0]   cnt_in;
   logic                   ready_ff;
   logic                   ready_in;
   logic                   accept;

   assign accept    = req_valid && ready_ff;
   assign req_ready = ready_ff;

   always_comb begin
      cmd          = '0;
      cmd.start    = accept;
      cmd.div_step = (state_ff == ST_DIVIDE);
      cmd.tbl_read = (state_ff == ST_READ);
      cmd.wr_pick  = (state_ff == ST_SWAP_PICK);
      cmd.wr_tail  = (state_ff == ST_SWAP_TAIL);
      cmd.finish   = (state_ff == ST_EMIT) && !sts.out_full;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ready_in = ready_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DIVIDE;
               cnt_in   = '0;
               ready_in = 1'b0;
            end
         end
         ST_DIVIDE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1))
               state_in = sts.distinct ? ST_READ : ST_EMIT;
         end
         ST_READ:      state_in = ST_SWAP_PICK;
         ST_SWAP_PICK: state_in = ST_SWAP_TAIL;
         ST_SWAP_TAIL: state_in = ST_EMIT;
         ST_EMIT: begin
            if (!sts.out_full) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ready_ff <= ready_in;
      end
   end

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (state_ff == ST_IDLE))
      else $error("ready outside idle");

   a_accept_starts_divide: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_DIVIDE) && (cnt_ff == '0))
      else $error("accepted beat did not start divide");

endmodule

`default_nettype wire

FILE: rtl/core/rcs_dp.sv
// Datapath: config registers, radix-16 remainder unit, symbol table, result register.
`default_nettype none

module rcs_dp
   import rcs_pkg::*;
#(
   parameter int MAX_CODE_LENGTH = 16,
   parameter int ALPHABET_SIZE   = 62
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rcs_cmd_type       cmd,
   output rcs_sts_type            sts,
   input  wire logic [WORD_W-1:0] req_random_word,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [CFG_W-1:0]  csr_wdata,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [6:0]             rsp_code_char,
   output logic [3:0]             rsp_char_position,
   output logic                   rsp_last_of_code
);

   localparam int PW = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1;
   localparam int TW = $clog2(ALPHABET_SIZE);
   localparam logic [SYM_W-1:0] MAX_LEN  = SYM_W'(MAX_CODE_LENGTH);
   localparam logic [SYM_W-1:0] ALPHA_SZ = SYM_W'(ALPHABET_SIZE);

   logic [1:0]            mode_ff;
   logic [LEN_W-1:0]      length_ff;
   logic [PW-1:0]         pos_ff;
   logic [PW-1:0]         pos_in;
   logic                  distinct;
   logic [SYM_W-1:0]      alpha;
   logic [SYM_W-1:0]      eff_len;
   logic [SYM_W:0]        pos_ext;
   logic                  last;
   logic                  restart;

   logic [DIV_WORD_W-1:0] word_ff;
   logic [SYM_W-1:0]      divisor_ff;
   logic [SYM_W-1:0]      rem_ff;
   logic [SYM_W-1:0]      rem_in;
   logic                  use_table_ff;

   logic [SYM_W-1:0]      tbl_mem [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] tbl_vld_ff;
   logic [SYM_W-1:0]      pick_q_ff;
   logic [SYM_W-1:0]      tail_q_ff;
   logic                  pick_v_ff;
   logic                  tail_v_ff;
   logic [TW-1:0]         pick_addr;
   logic [TW-1:0]         tail_addr;
   logic [SYM_W-1:0]      tail_idx;
   logic [SYM_W-1:0]      pick_sym;
   logic [SYM_W-1:0]      tail_sym;

   logic                  rsp_valid_ff;
   logic [6:0]            char_ff;
   logic [3:0]            cpos_ff;
   logic                  last_ff;
   logic [PW+3:0]         pos_wide;

   // effective code length
   assign distinct = (mode_ff == MODE_DISTINCT_DIGITS) || (mode_ff == MODE_DISTINCT_ALNUM);
   assign alpha    = (mode_ff == MODE_DISTINCT_ALNUM) ? ALPHA_SZ : DIGIT_COUNT;

   always_comb begin
      eff_len = {1'b0, length_ff};
      if (eff_len == '0)
         eff_len = SYM_W'(1);
      if (eff_len > MAX_LEN)
         eff_len = MAX_LEN;
      if (distinct && (eff_len > alpha))
         eff_len = alpha;
   end

   assign pos_ext = (SYM_W + 1)'(pos_ff) + 1'b1;
   assign last    = pos_ext >= {1'b0, eff_len};
   assign restart = csr_we || (cmd.finish && last);

   always_comb begin
      pos_in = pos_ff;
      if (restart)
         pos_in = '0;
      else if (cmd.finish)
         pos_in = pos_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_DIGITS;
         length_ff <= CODE_LENGTH_RESET;
         pos_ff    <= '0;
      end else begin
         pos_ff <= pos_in;
         if (csr_we) begin
            case (csr_index)
               CSR_CODE_MODE:   mode_ff   <= csr_wdata[1:0];
               CSR_CODE_LENGTH: length_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // remainder unit: four bits of the word per step
   always_comb begin
      logic [SYM_W:0] r;
      r = {1'b0, rem_ff};
      for (int i = 0; i < DIV_RADIX_BITS; i++) begin
         r = {r[SYM_W-1:0], word_ff[DIV_WORD_W-1-i]};
         if (r >= {1'b0, divisor_ff})
            r = r - {1'b0, divisor_ff};
      end
      rem_in = r[SYM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         word_ff <= {{(DIV_WORD_W - WORD_W){1'b0}}, req_random_word};
         rem_ff  <= '0;
         if (distinct && ((SYM_W)'(pos_ff) < alpha)) begin
            divisor_ff   <= alpha - SYM_W'(pos_ff);
            use_table_ff <= 1'b1;
         end else begin
            divisor_ff   <= DIGIT_COUNT;
            use_table_ff <= 1'b0;
         end
      end else if (cmd.div_step) begin
         word_ff <= word_ff << DIV_RADIX_BITS;
         rem_ff  <= rem_in;
      end
   end

   // symbol table; an entry without its valid bit reads as its own index
   assign tail_idx  = divisor_ff - 1'b1;
   assign pick_addr = rem_ff[TW-1:0];
   assign tail_addr = tail_idx[TW-1:0];
   assign pick_sym  = pick_v_ff ? pick_q_ff : SYM_W'(pick_addr);
   assign tail_sym  = tail_v_ff ? tail_q_ff : SYM_W'(tail_addr);

   always_ff @(posedge clock) begin
      if (cmd.tbl_read) begin
         pick_q_ff <= tbl_mem[pick_addr];
         tail_q_ff <= tbl_mem[tail_addr];
      end
      if (cmd.wr_pick)
         tbl_mem[pick_addr] <= tail_sym;
      else if (cmd.wr_tail)
         tbl_mem[tail_addr] <= pick_sym;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         tbl_vld_ff <= '0;
      end else begin
         if (cmd.wr_pick)
            tbl_vld_ff[pick_addr] <= 1'b1;
         else if (cmd.wr_tail)
            tbl_vld_ff[tail_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tbl_read) begin
         pick_v_ff <= tbl_vld_ff[pick_addr];
         tail_v_ff <= tbl_vld_ff[tail_addr];
      end
   end

   // result register
   assign pos_wide = {4'b0, pos_ff};

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.finish)
         rsp_valid_ff <= 1'b1;
      else if (rsp_ready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         char_ff <= use_table_ff ? sym_ascii(pick_sym) : ASCII_ZERO + {3'b0, rem_ff[3:0]};
         cpos_ff <= pos_wide[3:0];
         last_ff <= last;
      end
   end

   assign sts.distinct     = use_table_ff;
   assign sts.out_full     = rsp_valid_ff && !rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_code_char     = char_ff;
   assign rsp_char_position = cpos_ff;
   assign rsp_last_of_code  = last_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> rem_ff < divisor_ff)
      else $error("remainder not reduced below divisor");

   a_pos_in_code: assert property (@(posedge clock) disable iff (reset)
      {1'b0, pos_ff} < (PW + 1)'(eff_len) || PW >= SYM_W)
      else $error("position beyond code length");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && last) |=> (pos_ff == '0) && (tbl_vld_ff == '0))
      else $error("code end did not restart table");

endmodule

`default_nettype wire

FILE: rtl/core/random_code_sampler_core.sv
// Top level of the random code sampler: controller plus datapath.
//
//  channel | ports                                   | direction
//  req     | req_valid/req_ready, req_random_word    | in, one random word per beat
//  rsp     | rsp_valid/rsp_ready, code char/pos/last | out, one character per beat
//  csr     | csr_we, csr_index, csr_wdata            | in, write only, no wait
//
// A beat runs accept, the radix-16 remainder unit and the result load; in distinct
// modes a table read and a swap over its single write port come before the load.
// One beat is worked at a time.
// Reset restores identity table, position 0, mode 0, length 4, at once.
// A stalled result holds in the output register; the next word is taken meanwhile.
`default_nettype none

module random_code_sampler_core
   import rcs_pkg::*;
#(
   parameter int MAX_CODE_LENGTH = 16,
   parameter int ALPHABET_SIZE   = 62
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [WORD_W-1:0] req_random_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [6:0]             rsp_code_char,
   output logic [3:0]             rsp_char_position,
   output logic                   rsp_last_of_code,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [CFG_W-1:0]  csr_wdata
);

   rcs_cmd_type cmd;
   rcs_sts_type sts;

   rcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rcs_dp #(
      .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
      .ALPHABET_SIZE   (ALPHABET_SIZE)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_random_word   (req_random_word),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_char     (rsp_code_char),
      .rsp_char_position (rsp_char_position),
      .rsp_last_of_code  (rsp_last_of_code)
   );

endmodule

`default_nettype wire
